// ----- rtl/stack_list_with_cursor_macros.svh -----
// Assertion macros shared by the list controller and datapath.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef STACK_LIST_WITH_CURSOR_MACROS_SVH
`define STACK_LIST_WITH_CURSOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SLC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define SLC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define SLC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SLC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/slc_pkg.sv -----
// Shared constants, command and status codes, and controller commands
// for the list with cursor. No dependencies.
`default_nettype none

package slc_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int PTR_W   = $clog2(DEPTH);

   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_NEWER  = 3'd2,
      CMD_OLDER  = 3'd3,
      CMD_DELETE = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_END   = 2'd3
   } status_type;

   typedef struct packed {
      logic exec;
      logic report;
   } ctl_type;

endpackage

`default_nettype wire

// ----- rtl/slc_ctrl.sv -----
// Request sequencer: accepts a request, then schedules the result readout.
// Depends on slc_pkg and the assertion macro header.
`default_nettype none
`include "stack_list_with_cursor_macros.svh"

module slc_ctrl
   import slc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output logic      rsp_strobe,
   output ctl_type   ctl
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff;
   logic      strobe_ff;
   logic      accept;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = strobe_ff;
   assign ctl.exec   = accept;
   assign ctl.report = (state_ff == S_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == S_READ);
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `SLC_ASSERT_NXT(a_accept_reads, clock, reset, accept, state_ff == S_READ && !strobe_ff)
   `SLC_ASSERT_NXT(a_read_strobes, clock, reset, state_ff == S_READ, strobe_ff && !busy)

endmodule

`default_nettype wire

// ----- rtl/slc_dpath.sv -----
// Shifting cell chain with fill count, cursor and result registers.
// Depends on slc_pkg and the assertion macro header.
`default_nettype none
`include "stack_list_with_cursor_macros.svh"

module slc_dpath
   import slc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_type            ctl,
   input  wire logic [2:0]         req_cmd,
   input  wire logic signed [31:0] req_value,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_count,
   output logic [3:0]              rsp_cursor_pos,
   output logic signed [31:0]      rsp_cursor_value
);

   logic [VALUE_W-1:0] cells_ff [DEPTH];
   logic [VALUE_W-1:0] cells_in [DEPTH];
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [PTR_W-1:0]   cursor_ff, cursor_in;
   status_type         status_ff, status_in;

   status_type         rsp_status_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic [PTR_W-1:0]   rsp_cursor_pos_ff;
   logic [VALUE_W-1:0] rsp_cursor_value_ff;

   logic               empty;
   logic               full;
   logic               do_push;
   logic               do_remove;
   logic [PTR_W-1:0]   remove_pos;

   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == CNT_W'(DEPTH));

   always_comb begin
      status_in  = ST_DONE;
      fill_in    = fill_ff;
      cursor_in  = cursor_ff;
      do_push    = 1'b0;
      do_remove  = 1'b0;
      remove_pos = cursor_ff;
      unique case (req_cmd)
         CMD_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               do_push   = 1'b1;
               fill_in   = fill_ff + CNT_W'(1);
               cursor_in = empty ? '0 : cursor_ff + PTR_W'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               do_remove  = 1'b1;
               remove_pos = '0;
               fill_in    = fill_ff - CNT_W'(1);
               if (cursor_ff != '0) cursor_in = cursor_ff - PTR_W'(1);
            end
         end
         CMD_NEWER: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (cursor_ff == '0) begin
               status_in = ST_END;
            end else begin
               cursor_in = cursor_ff - PTR_W'(1);
            end
         end
         CMD_OLDER: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if ((CNT_W'(cursor_ff) + CNT_W'(1)) >= fill_ff) begin
               status_in = ST_END;
            end else begin
               cursor_in = cursor_ff + PTR_W'(1);
            end
         end
         CMD_DELETE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               do_remove = 1'b1;
               fill_in   = fill_ff - CNT_W'(1);
               if (cursor_ff != '0) cursor_in = cursor_ff - PTR_W'(1);
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_push) begin
            cells_in[i] = (i == 0) ? req_value[VALUE_W-1:0] : cells_ff[(i == 0) ? 0 : i - 1];
         end else if (do_remove && (PTR_W'(i) >= remove_pos) && (i < DEPTH - 1)) begin
            cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
      if (ctl.report) begin
         rsp_count_ff        <= fill_ff;
         rsp_cursor_pos_ff   <= empty ? '0 : cursor_ff;
         rsp_cursor_value_ff <= empty ? '0 : cells_ff[cursor_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         cursor_ff     <= '0;
         status_ff     <= ST_DONE;
         rsp_status_ff <= ST_DONE;
      end else begin
         if (ctl.exec) begin
            fill_ff   <= fill_in;
            cursor_ff <= cursor_in;
            status_ff <= status_in;
         end
         if (ctl.report) begin
            rsp_status_ff <= status_ff;
         end
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_cursor_pos   = rsp_cursor_pos_ff;
   assign rsp_cursor_value = rsp_cursor_value_ff;

   `SLC_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(DEPTH))
   `SLC_ASSERT_IMP(a_cursor_in_list, clock, reset, !empty, CNT_W'(cursor_ff) < fill_ff)
   `SLC_ASSERT_NXT(a_refusal_holds, clock, reset, ctl.exec && status_in != ST_DONE, $stable(fill_ff))

endmodule

`default_nettype wire

// ----- rtl/stack_list_with_cursor.sv -----
// The cell chain updates at the request edge; the cell under the cursor is then read
// into the result registers and the result strobe rises. A new request is not taken
// until that read is done; busy is high while the read is under way.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Synchronous reset empties the list and zeroes the cursor; cells keep old data.
`default_nettype none

module stack_list_with_cursor
   import slc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_cmd,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_count,
   output logic [3:0]              rsp_cursor_pos,
   output logic signed [31:0]      rsp_cursor_value
);

   ctl_type ctl;

   slc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl        (ctl)
   );

   slc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_cursor_value (rsp_cursor_value)
   );

endmodule

`default_nettype wire

// ----- dv/tb_stack_list_with_cursor.sv -----
// Self-checking testbench for stack_list_with_cursor: directed table, then bursty
// random commands, each strobed response checked against its table entry or a behavioral list model.
// Depends on slc_pkg and the stack_list_with_cursor RTL.
`timescale 1ns / 1ps

module tb_stack_list_with_cursor;
   import slc_pkg::*;

   localparam int         LIMIT        = 100000;
   localparam int         RANDOM_ITEMS = 765;
   localparam logic [2:0] CMD_RSVD5    = 3'd5;
   localparam logic [2:0] CMD_RSVD6    = 3'd6;
   localparam logic [2:0] CMD_RSVD7    = 3'd7;

   typedef struct {
      status_type               status;
      logic [CNT_W-1:0]         count;
      logic [PTR_W-1:0]         pos;
      logic signed [VALUE_W-1:0] value;
   } rsp_type;

   typedef struct {
      logic [2:0]                op;
      logic signed [VALUE_W-1:0] word;
      int                        rep;
      bit                        typed;
      rsp_type                   want;
   } plan_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic [2:0]                req_cmd   = CMD_PUSH;
   logic signed [31:0]        req_value = '0;
   logic                      busy;
   logic                      rsp_strobe;
   logic [1:0]                rsp_status;
   logic [4:0]                rsp_count;
   logic [3:0]                rsp_cursor_pos;
   logic signed [31:0]        rsp_cursor_value;

   logic signed [VALUE_W-1:0] shadow_cells [DEPTH];
   int                        shadow_fill   = 0;
   int                        shadow_cursor = 0;
   rsp_type                   pending_rsp [$];
   plan_row_type              plan [$];
   int                        errors = 0;
   int                        cycles = 0;

   stack_list_with_cursor DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_cursor_value (rsp_cursor_value)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic void drop_cell(input int p);
      int i;
      for (i = p; i < shadow_fill - 1; i++)
         shadow_cells[i] = shadow_cells[i + 1];
      shadow_fill--;
   endfunction

   function automatic void predict_list(input logic [2:0] op,
                                        input logic signed [VALUE_W-1:0] word,
                                        output rsp_type r);
      int i;
      r.status = ST_DONE;
      if (op != CMD_PUSH && op <= CMD_DELETE && shadow_fill == 0) begin
         r.status = ST_EMPTY;
      end else begin
         case (op)
            CMD_PUSH: begin
               if (shadow_fill >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  for (i = shadow_fill; i > 0; i--)
                     shadow_cells[i] = shadow_cells[i - 1];
                  if (shadow_fill > 0) shadow_cursor++;
                  else shadow_cursor = 0;
                  shadow_cells[0] = word;
                  shadow_fill++;
               end
            end
            CMD_POP: begin
               drop_cell(0);
               if (shadow_cursor > 0) shadow_cursor--;
            end
            CMD_NEWER: begin
               if (shadow_cursor == 0) r.status = ST_END;
               else shadow_cursor--;
            end
            CMD_OLDER: begin
               if (shadow_cursor + 1 >= shadow_fill) r.status = ST_END;
               else shadow_cursor++;
            end
            CMD_DELETE: begin
               if (shadow_cursor < shadow_fill) drop_cell(shadow_cursor);
               if (shadow_cursor > 0) shadow_cursor--;
            end
            default: ;
         endcase
      end
      if (shadow_fill == 0 || shadow_cursor >= shadow_fill) shadow_cursor = 0;
      r.count = CNT_W'(shadow_fill);
      r.pos   = (shadow_fill == 0) ? '0 : PTR_W'(shadow_cursor);
      r.value = (shadow_fill == 0) ? '0 : shadow_cells[shadow_cursor];
   endfunction

   function automatic plan_row_type mk_row(input logic [2:0] op,
                                           input logic signed [VALUE_W-1:0] word,
                                           input int rep, input bit typed,
                                           input status_type st, input int cnt,
                                           input int pos,
                                           input logic signed [VALUE_W-1:0] val);
      plan_row_type p;
      p.op          = op;
      p.word        = word;
      p.rep         = rep;
      p.typed       = typed;
      p.want.status = st;
      p.want.count  = CNT_W'(cnt);
      p.want.pos    = PTR_W'(pos);
      p.want.value  = val;
      return p;
   endfunction

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic send_request(input logic [2:0] op, input logic signed [31:0] word,
                               input bit typed, input rsp_type fixed);
      rsp_type r;
      @(negedge clock);
      start     <= 1'b1;
      req_cmd   <= op;
      req_value <= word;
      do @(posedge clock); while (busy);
      predict_list(op, word, r);
      pending_rsp.push_back(typed ? fixed : r);
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return -32'sd1;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [2:0] pick_op(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         0, 1, 2, 3: return (roll < 70) ? CMD_PUSH : 3'($urandom_range(1, 4));
         4, 5:       return (roll < 80) ? 3'($urandom_range(2, 3)) : 3'($urandom_range(0, 4));
         6, 7:       return (roll < 70) ? ((roll < 35) ? CMD_POP : CMD_DELETE)
                                        : 3'($urandom_range(0, 4));
         8:          return 3'($urandom_range(0, 4));
         default:    return 3'($urandom_range(0, 7));
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d count=%0d pos=%0d value=%0d",
                     $time, rsp_status, rsp_count, rsp_cursor_pos, rsp_cursor_value);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_count !== want.count ||
                rsp_cursor_pos !== want.pos || rsp_cursor_value !== want.value) begin
               $display("%0t: mismatch expected status=%0d count=%0d pos=%0d value=%0d",
                        $time, want.status, want.count, want.pos, want.value);
               $display("%0t:          actual   status=%0d count=%0d pos=%0d value=%0d",
                        $time, rsp_status, rsp_count, rsp_cursor_pos, rsp_cursor_value);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp_type      blank;
      plan_row_type p;
      logic [2:0]   op;
      int           sent;
      int           mode;
      int           burst;
      int           k;

      blank = '{ST_DONE, '0, '0, '0};
      sent  = 0;

      plan.push_back(mk_row(CMD_POP,    '0, 1, 1, ST_EMPTY, 0, 0, '0));
      plan.push_back(mk_row(CMD_NEWER,  '0, 1, 1, ST_EMPTY, 0, 0, '0));
      plan.push_back(mk_row(CMD_OLDER,  '0, 1, 1, ST_EMPTY, 0, 0, '0));
      plan.push_back(mk_row(CMD_DELETE, '0, 1, 1, ST_EMPTY, 0, 0, '0));
      plan.push_back(mk_row(CMD_RSVD5,  '0, 1, 1, ST_DONE,  0, 0, '0));
      plan.push_back(mk_row(CMD_PUSH, 32'sh7fffffff, 1, 1, ST_DONE, 1, 0, 32'sh7fffffff));
      plan.push_back(mk_row(CMD_NEWER,  '0, 1, 1, ST_END, 1, 0, 32'sh7fffffff));
      plan.push_back(mk_row(CMD_OLDER,  '0, 1, 1, ST_END, 1, 0, 32'sh7fffffff));
      plan.push_back(mk_row(CMD_PUSH, 32'sh80000000, 1, 1, ST_DONE, 2, 1, 32'sh7fffffff));
      plan.push_back(mk_row(CMD_OLDER,  '0, 1, 1, ST_END, 2, 1, 32'sh7fffffff));
      plan.push_back(mk_row(CMD_NEWER,  '0, 1, 1, ST_DONE, 2, 0, 32'sh80000000));
      plan.push_back(mk_row(CMD_POP,    '0, 1, 1, ST_DONE, 1, 0, 32'sh7fffffff));
      plan.push_back(mk_row(CMD_PUSH, 32'sh55555555, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_PUSH, 32'shaaaaaaaa, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_PUSH, -32'sd1, 13, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_PUSH, 32'sd1, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_OLDER,  '0, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_NEWER,  '0, 3, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_DELETE, '0, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_RSVD6,  '0, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_RSVD7,  '0, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_NEWER,  '0, 16, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_DELETE, '0, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_OLDER,  '0, 16, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_DELETE, '0, 1, 0, ST_DONE, 0, 0, '0));
      plan.push_back(mk_row(CMD_POP,    '0, 16, 0, ST_DONE, 0, 0, '0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         p = plan[i];
         repeat (p.rep) send_request(p.op, p.word, p.typed, p.want);
      end

      // hold off until the directed responses have drained
      idle_cycles(1);
      while (pending_rsp.size() != 0) @(negedge clock);

      while (sent < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 9);
         burst = $urandom_range(1, 24);
         for (k = 0; k < burst; k++) begin
            op = pick_op(mode);
            send_request(op, pick_word(), 1'b0, blank);
            if (op <= CMD_DELETE) sent++;
         end
         if ($urandom_range(0, 19) == 0) begin
            idle_cycles(1);
            while (pending_rsp.size() != 0) @(negedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 6));
         end
      end

      idle_cycles(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
